// ----- sv/uvs_pkg.sv -----
// Shared types and constants of the UV lamp alarm supervisor.
package uvs_pkg;

	// Fixed field widths and constants.
	localparam int unsigned BaseLamps = 10;
	localparam int unsigned LampFieldW = 10;
	localparam int unsigned PctFull = 100;
	localparam int unsigned UvHyst = 5;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 12;

	// Register reset values.
	localparam logic [6:0] RstUvMin = 7'd40;
	localparam logic [6:0] RstTempMax = 7'd55;
	localparam logic [6:0] RstTempRecover = 7'd20;
	localparam logic RstSensorPresent = 1'b1;
	localparam logic [11:0] RstFsInit = 12'd1000;
	localparam logic [3:0] RstLampCount = 4'd5;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		RegUvMin = 3'd0,
		RegTempMax = 3'd1,
		RegTempRecover = 3'd2,
		RegSensorPresent = 3'd3,
		RegFsInit = 3'd4,
		RegLampCount = 3'd5
	} cfg_reg_t;

	// One check word.
	typedef struct packed {
		logic [15:0] uv_raw;
		logic [7:0] water_temp;
		logic [9:0] base_fault_bits;
		logic [15:0] expansion_fault_bits;
		logic uv_enabled;
		logic us_requested;
	} chk_word_t;

	// One result word.
	typedef struct packed {
		logic [6:0] uv_percent;
		logic lamp_alarm;
		logic uv_low_alarm;
		logic temp_alarm;
		logic alarm_led;
		logic uv_relay;
		logic us_relay;
		logic [9:0] lamp_ok_flags;
		logic display_update;
	} res_word_t;

	// Alarm flags.
	typedef struct packed {
		logic lamp;
		logic uv;
		logic temp;
	} flags_t;

	// Configuration register file.
	typedef struct packed {
		logic [6:0] uv_min_percent;
		logic [6:0] temp_max;
		logic [6:0] temp_recover;
		logic sensor_board_present;
		logic [11:0] uv_full_scale_init;
		logic [3:0] base_lamp_count;
	} cfg_regs_t;

endpackage

// ----- sv/uvs_if.sv -----
// Handshake channel interfaces of the UV lamp alarm supervisor.
interface uvs_chk_if;
	import uvs_pkg::*;
	logic valid;
	logic ready;
	chk_word_t word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface uvs_res_if;
	import uvs_pkg::*;
	logic valid;
	logic ready;
	res_word_t word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface uvs_cfg_if;
	import uvs_pkg::*;
	logic valid;
	logic ready;
	logic [CfgIdxW-1:0] index;
	logic [CfgDataW-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/uvs_div.sv -----
// Serial percent unit: shift-add multiply by 100, then one quotient bit per cycle.
module uvs_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [15:0] raw,
	input logic [15:0] fs,
	output logic done,
	output logic [6:0] pct
);
	import uvs_pkg::*;

	typedef enum logic [2:0] {
		DivIdle = 3'b001,
		DivMul = 3'b010,
		DivRun = 3'b100
	} div_state_t;

	div_state_t state_q;
	logic [22:0] acc_q;
	logic [15:0] raw_q;
	logic [21:0] dvs_q;
	logic [6:0] quo_q;
	logic [2:0] step_q;
	logic done_q;
	logic [22:0] addend;
	logic fits;

	// Multiply by 100 as raw*4 + raw*32 + raw*64, one add per cycle.
	assign addend = step_q[0] ? {1'b0, raw_q, 6'b0} : {2'b0, raw_q, 5'b0};
	// Restoring division compare against the shifted divisor.
	assign fits = (acc_q >= {1'b0, dvs_q});

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DivIdle;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			case (state_q)
				DivIdle: begin
					if (start) begin
						done_q <= 1'b0;
						step_q <= '0;
						if (raw > fs) begin
							done_q <= 1'b1;
						end else if (fs == 16'd0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= DivMul;
						end
					end
				end
				DivMul: begin
					step_q <= step_q + 3'd1;
					if (step_q[0]) begin
						step_q <= '0;
						state_q <= DivRun;
					end
				end
				DivRun: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd6) begin
						done_q <= 1'b1;
						state_q <= DivIdle;
					end
				end
				default: begin
					state_q <= DivIdle;
				end
			endcase
		end
	end

	// Accumulator, divisor shift register and quotient shift register.
	always_ff @(posedge clk) begin
		case (state_q)
			DivIdle: begin
				if (start) begin
					raw_q <= raw;
					acc_q <= {5'b0, raw, 2'b0};
					dvs_q <= {fs, 6'b0};
					if (raw > fs) begin
						quo_q <= 7'(PctFull);
					end else begin
						quo_q <= '0;
					end
				end
			end
			DivMul: begin
				acc_q <= acc_q + addend;
			end
			DivRun: begin
				if (fits) begin
					acc_q <= acc_q - {1'b0, dvs_q};
				end
				quo_q <= {quo_q[5:0], fits};
				dvs_q <= {1'b0, dvs_q[21:1]};
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign done = done_q;
	assign pct = quo_q;

	// A new operand pair arrives only while the unit is free.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == DivIdle))
		else $error("percent unit started while busy");
	// The quotient never exceeds full percent once finished.
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (quo_q <= 7'(PctFull)))
		else $error("percent above full scale");
	// Done falls on the cycle after a start that needs a division.
	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && (raw <= fs) && (fs != 16'd0)) |=> !done_q)
		else $error("stale done after start");

endmodule

// ----- sv/uvs_alarm.sv -----
// Alarm flag update and result word assembly for one check.
module uvs_alarm (
	input uvs_pkg::cfg_regs_t regs,
	input uvs_pkg::flags_t flags,
	input uvs_pkg::chk_word_t item,
	input logic [6:0] pct,
	output uvs_pkg::flags_t flags_nxt,
	output uvs_pkg::res_word_t word
);
	import uvs_pkg::*;

	logic [3:0] lamp_cnt;
	logic [LampFieldW-1:0] lamp_mask;
	logic [LampFieldW-1:0] base_masked;
	logic faults_any;
	logic [7:0] uv_clear_lvl;

	// Clamp the fitted lamp count to one through the board size.
	always_comb begin
		if (regs.base_lamp_count == 4'd0) begin
			lamp_cnt = 4'd1;
		end else if (regs.base_lamp_count > 4'(BaseLamps)) begin
			lamp_cnt = 4'(BaseLamps);
		end else begin
			lamp_cnt = regs.base_lamp_count;
		end
	end

	// Mask of the fitted lamps.
	always_comb begin
		for (int i = 0; i < LampFieldW; i++) begin
			lamp_mask[i] = (4'(i) < lamp_cnt);
		end
	end

	assign base_masked = item.base_fault_bits & lamp_mask;
	assign faults_any = (|base_masked) | (|item.expansion_fault_bits);
	assign uv_clear_lvl = {1'b0, regs.uv_min_percent} + 8'(UvHyst);

	// Flag update: alarms move only while UV is on, sensor alarms need the board.
	always_comb begin
		flags_nxt = flags;
		if (item.uv_enabled) begin
			flags_nxt.lamp = faults_any;
			if (regs.sensor_board_present) begin
				if (pct < regs.uv_min_percent) begin
					flags_nxt.uv = 1'b1;
				end else if (flags.uv && ({1'b0, pct} > uv_clear_lvl)) begin
					flags_nxt.uv = 1'b0;
				end
				if (item.water_temp > {1'b0, regs.temp_max}) begin
					flags_nxt.temp = 1'b1;
				end else if (flags.temp && (item.water_temp < {1'b0, regs.temp_recover})) begin
					flags_nxt.temp = 1'b0;
				end
			end
		end
	end

	// Result word.
	always_comb begin
		word.uv_percent = pct;
		word.lamp_alarm = flags_nxt.lamp;
		word.uv_low_alarm = flags_nxt.uv;
		word.temp_alarm = flags_nxt.temp;
		word.alarm_led = item.uv_enabled & (flags_nxt.lamp | flags_nxt.uv | flags_nxt.temp);
		word.uv_relay = item.uv_enabled & ~flags_nxt.temp;
		word.us_relay = item.us_requested & ~flags_nxt.temp;
		word.lamp_ok_flags = ~base_masked;
		word.display_update = (flags_nxt != flags);
	end

endmodule

// ----- sv/uv_lamp_alarm_supervisor.sv -----
// Top level of the UV lamp alarm supervisor.
//
//  channel | dir | handshake     | word
//  chk     | in  | valid/ready   | uv_raw, water_temp, fault bits, enables
//  res     | out | valid/ready   | uv_percent, alarms, relays, lamp_ok_flags
//  cfg     | in  | valid/ready   | index (3 bits), data (12 bits)
//
// When a division is needed, an item passes from acceptance through the
// shift-add steps, the quotient bits and the commit before the next
// acceptance; when the reading is above full scale or full scale is 0, the
// division is skipped. The serial percent unit sets the pace. A result held on res
// stalls the commit, and with it the next acceptance. Reset loads the register
// defaults, clears the alarm flags and loads full scale with its initial value.
module uv_lamp_alarm_supervisor (
	input logic clk,
	input logic arst_n,
	uvs_chk_if.sink chk,
	uvs_res_if.source res,
	uvs_cfg_if.sink cfg
);
	import uvs_pkg::*;

	typedef enum logic [1:0] {
		StIdle = 2'b01,
		StCalc = 2'b10
	} st_t;

	st_t state_q;
	cfg_regs_t regs_q;
	flags_t flags_q;
	flags_t flags_nxt;
	logic [15:0] fs_q;
	chk_word_t chk_q;
	res_word_t res_word_q;
	res_word_t word_nxt;
	logic res_valid_q;
	logic chk_acc;
	logic cfg_wr;
	logic div_done;
	logic [6:0] div_pct;
	logic commit;

	assign chk.ready = (state_q == StIdle);
	assign chk_acc = chk.valid && chk.ready;
	assign cfg.ready = 1'b1;
	assign cfg_wr = cfg.valid;
	assign commit = (state_q == StCalc) && div_done && (!res_valid_q || res.ready);

	// Percent of full scale.
	uvs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(chk_acc),
		.raw(chk.word.uv_raw),
		.fs(fs_q),
		.done(div_done),
		.pct(div_pct)
	);

	// Alarm update and result assembly.
	uvs_alarm u_alarm (
		.regs(regs_q),
		.flags(flags_q),
		.item(chk_q),
		.pct(div_pct),
		.flags_nxt(flags_nxt),
		.word(word_nxt)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.uv_min_percent <= RstUvMin;
			regs_q.temp_max <= RstTempMax;
			regs_q.temp_recover <= RstTempRecover;
			regs_q.sensor_board_present <= RstSensorPresent;
			regs_q.uv_full_scale_init <= RstFsInit;
			regs_q.base_lamp_count <= RstLampCount;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(cfg.index))
				RegUvMin: regs_q.uv_min_percent <= cfg.data[6:0];
				RegTempMax: regs_q.temp_max <= cfg.data[6:0];
				RegTempRecover: regs_q.temp_recover <= cfg.data[6:0];
				RegSensorPresent: regs_q.sensor_board_present <= cfg.data[0];
				RegFsInit: regs_q.uv_full_scale_init <= cfg.data[11:0];
				RegLampCount: regs_q.base_lamp_count <= cfg.data[3:0];
				default: regs_q <= regs_q;
			endcase
		end
	end

	// Control, flags and tracked full scale.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			flags_q <= '0;
			fs_q <= {4'b0, RstFsInit};
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && (cfg_reg_t'(cfg.index) == RegFsInit)) begin
				fs_q <= {4'b0, cfg.data[11:0]};
			end
			case (state_q)
				StIdle: begin
					if (chk_acc) begin
						state_q <= StCalc;
					end
				end
				StCalc: begin
					if (commit) begin
						state_q <= StIdle;
						flags_q <= flags_nxt;
						if (chk_q.uv_raw > fs_q) begin
							fs_q <= chk_q.uv_raw;
						end
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
			if (commit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Check word and result word.
	always_ff @(posedge clk) begin
		if (chk_acc) begin
			chk_q <= chk.word;
		end
		if (commit) begin
			res_word_q <= word_nxt;
		end
	end

	assign res.valid = res_valid_q;
	assign res.word = res_word_q;

	// An over-temperature alarm always drops both relays.
	a_relays_off: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.word.temp_alarm) |-> (!res.word.uv_relay && !res.word.us_relay))
		else $error("relay on during temperature alarm");
	// The reported percent stays within full scale.
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.word.uv_percent <= 7'(PctFull)))
		else $error("percent above full");
	// Full scale never shrinks on a commit without a configuration write.
	a_fs_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !cfg_wr) |=> (fs_q >= $past(fs_q)))
		else $error("full scale shrank on a check");
	// An accepted word always starts a calculation.
	a_acc_calc: assert property (@(posedge clk) disable iff (!arst_n)
		chk_acc |=> (state_q == StCalc))
		else $error("accepted word not processed");

endmodule
